// ===== hdl/auto_range_histogram_macros.svh =====
// Assertion macros for the auto-ranging histogram block.
// Used by the top level only; no other dependencies.
`ifndef AUTO_RANGE_HISTOGRAM_MACROS_SVH
`define AUTO_RANGE_HISTOGRAM_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define ARH_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ARH_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hdl/arh_pkg.sv =====
// Shared constants and types for the auto-ranging histogram block.
// No dependencies.
package arh_pkg;
  localparam int MaxSamples = 4096;
  localparam int MaxBins = 128;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CntW = AddrW + 1;
  localparam int BinW = $clog2(MaxBins);
  localparam logic [12:0] CountMax = 13'd8191;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoBin = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StDropped = 2'd3;

  localparam logic [1:0] RegBins = 2'd0;
  localparam logic [1:0] RegSel = 2'd1;
  localparam logic [1:0] RegTot = 2'd2;

  // Item passed from the front part to the back part.
  typedef struct packed {
    logic               is_read;
    logic signed [31:0] value;
    logic [BinW-1:0]    bin;
  } cmd_t;
endpackage

// ===== hdl/arh_front.sv =====
// Front part: accepts items, filters samples by component, queues commands.
// Depends on arh_pkg.
module arh_front import arh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_cmd,
  input  logic signed [31:0] in_sample_value,
  input  logic [3:0]         in_sample_component,
  input  logic [6:0]         in_bin_index,
  input  logic [3:0]         sel_eff,
  output logic               q_valid,
  output cmd_t               q_data,
  input  logic               q_pop
);
  cmd_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       keep, wr, rd;

  // Keep reads and samples of the effective component.
  assign keep = in_cmd || (in_sample_component == sel_eff);
  assign in_full = (cnt_r == 3'd4);
  assign wr = in_push && !in_full && keep;
  assign rd = q_pop && q_valid;
  assign q_valid = (cnt_r != 3'd0);
  assign q_data = mem_r[rp_r];

  // Advance the queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end

  // Store the entry.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= '{is_read: in_cmd, value: in_sample_value, bin: in_bin_index};
    end
  end
endmodule

// ===== hdl/arh_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend / 33-bit divisor.
// Depends on arh_pkg.
module arh_div import arh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] d_r;
  logic [5:0]  n_r;
  logic        busy_r, done_r;
  logic [33:0] sh;
  logic        ge;

  assign sh = {rem_r[32:0], q_r[47]};
  assign ge = sh >= {1'b0, d_r};
  assign done = done_r;
  assign quotient = q_r;

  // Shift and subtract one bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r <= 6'd48;
        q_r <= dividend;
        rem_r <= '0;
        d_r <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? sh - {1'b0, d_r} : sh;
        q_r <= {q_r[46:0], ge};
        n_r <= n_r - 6'd1;
        if (n_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/arh_back.sv =====
// Back part: sample buffer, min/max scan, binning pass and bin reads.
// Depends on arh_pkg and arh_div.
module arh_back import arh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_data,
  output logic               q_pop,
  input  logic [7:0]         bin_cfg,
  input  logic               bins_wr,
  input  logic               res_space,
  output logic               res_load,
  output logic signed [39:0] res_center,
  output logic [12:0]        res_total,
  output logic [1:0]         res_status
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MM, S_MMW, S_BRD, S_BST, S_BDIV, S_BUPD, S_RDIV, S_RESP
  } state_t;

  state_t              st_r;
  logic signed [31:0]  store_m [MaxSamples];
  logic [12:0]         bins_m [MaxBins];
  logic signed [31:0]  rd_data_r;
  logic [12:0]         bin_data_r;
  logic [CntW-1:0]     count_r, idx_r;
  logic                ovf_r, ready_r;
  logic signed [31:0]  lo_r, hi_r;
  logic [BinW-1:0]     bptr_r;
  logic [BinW:0]       clr_r;
  logic [7:0]          nb;
  logic [32:0]         range;
  logic                div_start;
  logic [47:0]         div_a;
  logic [32:0]         div_b;
  logic                div_done;
  logic [47:0]         div_q;
  logic signed [32:0]  off;
  logic [12:0]         rd_addr;
  logic [BinW-1:0]     bin_addr;

  // Clamp the configured bin count.
  assign nb = (bin_cfg == 8'd0) ? 8'd1 : (bin_cfg > 8'(MaxBins)) ? 8'(MaxBins) : bin_cfg;
  assign range = 33'($signed({hi_r[31], hi_r}) - $signed({lo_r[31], lo_r}));
  assign off = $signed({rd_data_r[31], rd_data_r}) - $signed({lo_r[31], lo_r});

  arh_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // Divider operands: binning pass or center offset.
  always_comb begin
    div_start = 1'b0;
    div_a = 48'(off) * 48'(nb - 8'd1);
    div_b = range;
    if (st_r == S_BST) div_start = 1'b1;
    if (st_r == S_IDLE && q_valid && q_data.is_read && count_r != '0 && ready_r
        && range != '0 && {1'b0, q_data.bin} < nb) begin
      div_start = 1'b1;
    end
    if (st_r != S_BST) begin
      div_a = (48'({q_data.bin, 1'b1}) * 48'(range)) << 7;
      div_b = 33'(nb);
    end
  end

  // Bin counter address: new bin at the end of a divide, requested bin while
  // a read is served, otherwise the bin being updated. A flat buffer uses bin 0.
  always_comb begin
    unique case (st_r)
      S_BDIV:                 bin_addr = (range == '0) ? '0 : div_q[BinW-1:0];
      S_IDLE, S_RDIV, S_RESP: bin_addr = q_data.bin;
      default:                bin_addr = bptr_r;
    endcase
  end

  assign rd_addr = (st_r == S_IDLE || st_r == S_CLR) ? 13'd0 : idx_r;
  assign q_pop = (st_r == S_IDLE && q_valid && !q_data.is_read) || (st_r == S_RESP && res_space)
                 || (st_r == S_IDLE && q_valid && q_data.is_read && count_r == '0 && res_space);

  // Sample buffer: write on push, registered read.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && !q_data.is_read && count_r < CntW'(MaxSamples)) begin
      store_m[count_r[AddrW-1:0]] <= q_data.value;
    end
    rd_data_r <= store_m[rd_addr[AddrW-1:0]];
  end

  // Bin counters: clear, increment, read.
  always_ff @(posedge clk) begin
    if (st_r == S_CLR) bins_m[clr_r[BinW-1:0]] <= '0;
    else if (st_r == S_BUPD && bin_data_r != CountMax) bins_m[bptr_r] <= bin_data_r + 13'd1;
    bin_data_r <= bins_m[bin_addr];
  end

  // Control sequencer and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      count_r <= '0;
      ovf_r <= 1'b0;
      ready_r <= 1'b0;
      lo_r <= '0;
      hi_r <= '0;
      res_load <= 1'b0;
      idx_r <= '0;
      clr_r <= '0;
      bptr_r <= '0;
    end else begin
      res_load <= 1'b0;
      if (bins_wr) ready_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          if (!q_data.is_read) begin
            if (count_r < CntW'(MaxSamples)) count_r <= count_r + 1'b1;
            else ovf_r <= 1'b1;
            ready_r <= 1'b0;
          end else if (count_r == '0) begin
            if (res_space) begin
              res_load <= 1'b1;
              res_center <= '0;
              res_total <= '0;
              res_status <= StEmpty;
            end
          end else if (!ready_r) begin
            clr_r <= '0;
            st_r <= S_CLR;
          end else if (range == '0 ? q_data.bin != '0 : {1'b0, q_data.bin} >= nb) begin
            res_center <= '0;
            res_total <= '0;
            res_status <= StNoBin;
            st_r <= S_RESP;
          end else if (range == '0) begin
            res_center <= 40'(lo_r) <<< 8;
            res_status <= ovf_r ? StDropped : StOk;
            st_r <= S_RESP;
          end else begin
            res_status <= ovf_r ? StDropped : StOk;
            st_r <= S_RDIV;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (BinW+1)'(MaxBins - 1)) begin
            lo_r <= rd_data_r;
            hi_r <= rd_data_r;
            idx_r <= CntW'(1);
            st_r <= S_MM;
          end
        end
        S_MM: st_r <= S_MMW;
        S_MMW: begin
          if (idx_r < count_r) begin
            if (rd_data_r < lo_r) lo_r <= rd_data_r;
            if (rd_data_r > hi_r) hi_r <= rd_data_r;
          end
          if (idx_r + 1'b1 >= count_r) begin
            idx_r <= '0;
            st_r <= S_BRD;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r <= S_MM;
          end
        end
        S_BRD: st_r <= S_BST;
        S_BST: st_r <= S_BDIV;
        S_BDIV: if (div_done) begin
          // A flat buffer has only bin 0.
          if (range == '0) bptr_r <= '0;
          else if (div_q > 48'(nb - 8'd1)) bptr_r <= BinW'(nb - 8'd1);
          else bptr_r <= div_q[BinW-1:0];
          st_r <= S_BUPD;
        end
        S_BUPD: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 >= count_r) begin
            ready_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            st_r <= S_BRD;
          end
        end
        S_RDIV: if (div_done) begin
          res_center <= (40'(lo_r) <<< 8) + 40'(div_q);
          st_r <= S_RESP;
        end
        S_RESP: if (res_space) begin
          if (res_status != StNoBin) res_total <= bin_data_r;
          res_load <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/auto_range_histogram.sv =====
// Auto-ranging histogram of one pixel component.
// Push a sample with cmd=0 when full is low; push a read with cmd=1 and a bin index.
// Each read gives one result on the out_ side (empty/pop); pushes give none.
// Samples are taken at one per cycle while full is low; the first read after new
// data or a bin_count write runs a pass: counter clearing, a min/max scan of the
// samples, and binning (one serial 48-bit divide per sample).
// Later reads of a present bin use the same serial divider for the center unless
// the buffer is flat; a read of an empty buffer or of a missing bin needs no
// divide. The back part takes no new item until a read's result is loaded.
// Reset empties the buffer and queues and restores bin_count 100,
// component_select 0, component_total 1. When pop is held low the result
// stays and the back part stalls at the next read; the 4-entry queue then fills and full rises.
// Depends on arh_pkg, arh_front, arh_back and the macros header.
`include "auto_range_histogram_macros.svh"
module auto_range_histogram import arh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_cmd,
  input  logic signed [31:0] in_sample_value,
  input  logic [3:0]         in_sample_component,
  input  logic [6:0]         in_bin_index,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [39:0] out_bin_center,
  output logic [12:0]        out_bin_total,
  output logic [1:0]         out_read_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  logic [7:0] bins_r;
  logic [3:0] sel_r;
  logic [4:0] tot_r;
  logic [3:0] sel_eff;
  logic       q_valid, q_pop, res_load, full_r;
  cmd_t       q_data;
  logic signed [39:0] c;
  logic [12:0] t;
  logic [1:0]  s;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= 8'd100;
      sel_r <= '0;
      tot_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBins: bins_r <= cfg_data;
        RegSel:  sel_r <= cfg_data[3:0];
        RegTot:  tot_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end
  assign sel_eff = ({1'b0, sel_r} < tot_r) ? sel_r : 4'd0;

  arh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .in_sample_value(in_sample_value), .in_sample_component(in_sample_component),
    .in_bin_index(in_bin_index), .sel_eff(sel_eff), .q_valid(q_valid),
    .q_data(q_data), .q_pop(q_pop)
  );

  arh_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .bin_cfg(bins_r), .bins_wr(cfg_we && cfg_index == RegBins),
    .res_space(!full_r && !res_load), .res_load(res_load),
    .res_center(c), .res_total(t), .res_status(s)
  );

  // Output register: one result slot.
  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (res_load) full_r <= 1'b1;
    else if (out_pop) full_r <= 1'b0;
    if (res_load) begin
      out_bin_center <= c;
      out_bin_total <= t;
      out_read_status <= s;
    end
  end
  assign out_empty = !full_r;

  `ARH_ASSERT_IMP(a_no_overwrite, res_load, !full_r)
  `ARH_ASSERT_NEXT(a_load_fills, res_load, !out_empty)
  `ARH_ASSERT_IMP(a_pop_valid, q_pop, q_valid)
endmodule

// ===== tb/tb_auto_range_histogram.sv =====
// Self-checking testbench for the auto-ranging histogram block.
// Depends on arh_pkg and the auto_range_histogram top level only.
module tb_auto_range_histogram;
  import arh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that maps to no register
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct {
    logic [39:0] center;
    logic [12:0] total;
    logic [1:0]  status;
  } bin_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic               in_cmd;
  logic signed [31:0] in_sample_value;
  logic [3:0]         in_sample_component;
  logic [6:0]         in_bin_index;
  logic               out_empty;
  logic               out_pop;
  logic signed [39:0] out_bin_center;
  logic [12:0]        out_bin_total;
  logic [1:0]         out_read_status;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  // Histogram predictor state
  int          held_samples[$];
  bit          drop_seen;
  int          low_val;
  int          high_val;
  int unsigned bin_tally[MaxBins];
  bit          tally_valid;
  int unsigned reg_bins;
  int unsigned reg_sel;
  int unsigned reg_tot;

  bin_result_t pending_bins[$];
  int          error_count;
  int          counted_items;
  int          read_transfers;
  int          checked_bins;
  bit          quiet;
  bit          stall_request;
  int          hold_left;
  int          cluster_base;

  auto_range_histogram uut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned effective_bins();
    if (reg_bins == 0) return 1;
    if (reg_bins > MaxBins) return MaxBins;
    return reg_bins;
  endfunction

  function automatic int unsigned effective_component();
    return (reg_sel < reg_tot) ? reg_sel : 0;
  endfunction

  // Find min/max, clear the tally and count every held sample into its bin
  function automatic void rebuild_histogram();
    longint unsigned span;
    longint unsigned offs;
    longint unsigned b;
    int unsigned nb;
    nb = effective_bins();
    foreach (bin_tally[i]) bin_tally[i] = 0;
    low_val = held_samples[0];
    high_val = held_samples[0];
    foreach (held_samples[i]) begin
      if (held_samples[i] < low_val) low_val = held_samples[i];
      if (held_samples[i] > high_val) high_val = held_samples[i];
    end
    span = longint'(high_val) - longint'(low_val);
    if (span == 0) begin
      bin_tally[0] = (held_samples.size() > CountMax) ? CountMax : held_samples.size();
    end else begin
      foreach (held_samples[i]) begin
        offs = longint'(held_samples[i]) - longint'(low_val);
        b = offs * (nb - 1) / span;
        if (b > nb - 1) b = nb - 1;
        if (bin_tally[b] < CountMax) bin_tally[b]++;
      end
    end
    tally_valid = 1'b1;
  endfunction

  // Advance the predictor by one accepted transfer
  function automatic void predict_transfer(bit cmd, int val, int unsigned comp,
                                           int unsigned idx);
    bin_result_t r;
    longint unsigned span;
    longint unsigned offs;
    int unsigned nb;
    counted_items++;
    if (!cmd) begin
      if (comp != effective_component()) return;
      if (held_samples.size() < MaxSamples) held_samples.insert(held_samples.size(), val);
      else drop_seen = 1'b1;
      tally_valid = 1'b0;
      return;
    end
    r.center = '0;
    r.total = '0;
    if (held_samples.size() == 0) begin
      r.status = StEmpty;
    end else begin
      if (!tally_valid) rebuild_histogram();
      span = longint'(high_val) - longint'(low_val);
      nb = (span == 0) ? 1 : effective_bins();
      if (idx >= nb) begin
        r.status = StNoBin;
      end else begin
        offs = longint'(2 * idx + 1) * span * 128 / nb;
        r.center = 40'(longint'(low_val) * 256 + longint'(offs));
        r.total = 13'(bin_tally[idx]);
        r.status = drop_seen ? StDropped : StOk;
      end
    end
    pending_bins.insert(pending_bins.size(), r);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(bit cmd, int val, int unsigned comp, int unsigned idx);
    int gap;
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_sample_value <= val;
    in_sample_component <= 4'(comp);
    in_bin_index <= 7'(idx);
    do @(posedge clk); while (in_full);
    predict_transfer(cmd, val, comp, idx);
    if (cmd) read_transfers++;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_sample(int val, int unsigned comp);
    send_item(1'b0, val, comp, $urandom_range(0, 127));
  endtask

  task automatic read_bin(int unsigned idx);
    send_item(1'b1, $urandom, $urandom_range(0, 15), idx);
  endtask

  // Drain all results, then let queued pushes settle
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 8'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegBins: begin
        reg_bins = val & 8'hFF;
        tally_valid = 1'b0;
      end
      RegSel: reg_sel = val & 4'hF;
      RegTot: reg_tot = val & 5'h1F;
      default: ;
    endcase
  endtask

  function automatic int random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return cluster_base + int'($urandom_range(0, 5000));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  // Empty buffer, then a flat histogram with a single bin
  task automatic test_empty_and_flat();
    read_bin(0);
    push_sample(7, 0);
    push_sample(7, 0);
    read_bin(0);
    read_bin(1);
    push_sample(7, 5);
  endtask

  // Full-scale span: extremes of the sample field and of the bin index
  task automatic test_extremes();
    push_sample(32'h8000_0000, 0);
    push_sample(32'h7FFF_FFFF, 0);
    push_sample(-1, 0);
    read_bin(0);
    read_bin(99);
    read_bin(100);
    read_bin(127);
  endtask

  // Bin count of zero, one, the maximum and above it; unused register index
  task automatic test_bin_count_limits();
    write_reg(RegBins, 0);
    read_bin(0);
    read_bin(1);
    write_reg(RegBins, 255);
    read_bin(127);
    write_reg(RegBins, 128);
    read_bin(64);
    write_reg(RegUnused, 8'hFF);
    read_bin(127);
    write_reg(RegBins, 1);
    read_bin(0);
  endtask

  // Component selection, fallback when the select is out of range
  task automatic test_component_select();
    write_reg(RegBins, 16);
    write_reg(RegTot, 0);
    write_reg(RegSel, 5);
    push_sample(40, 5);
    push_sample(-40, 0);
    read_bin(15);
    write_reg(RegTot, 4);
    write_reg(RegSel, 3);
    push_sample(1000, 3);
    push_sample(2000, 0);
    read_bin(8);
    write_reg(RegTot, 16);
    write_reg(RegSel, 15);
    push_sample(-3000, 15);
    read_bin(0);
  endtask

  // Hold the result side off long enough for the input side to stall
  task automatic test_backpressure();
    wait_idle();
    stall_request = 1'b1;
    repeat (14) read_bin($urandom_range(0, 20));
  endtask

  // Bursts of samples and reads with random content and register changes
  task automatic test_random();
    int stop_at;
    int n;
    int unsigned comp;
    stop_at = counted_items + 2000;
    while (counted_items < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          case ($urandom_range(0, 3))
            0: write_reg(RegBins, $urandom_range(0, 255));
            1: write_reg(RegSel, $urandom_range(0, 15));
            2: write_reg(RegTot, $urandom_range(0, 31));
            default: write_reg(RegBins, $urandom_range(1, 128));
          endcase
        end
        2, 3, 4, 5, 6, 7: begin
          n = $urandom_range(1, 20);
          repeat (n) begin
            comp = effective_component();
            if (held_samples.size() >= 300 || $urandom_range(0, 4) == 0)
              comp = (comp + $urandom_range(1, 15)) % 16;
            push_sample(random_value(), comp);
          end
        end
        default: begin
          n = $urandom_range(1, 30);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0) read_bin($urandom_range(0, 127));
            else read_bin($urandom_range(0, effective_bins() - 1));
          end
        end
      endcase
    end
  endtask

  // Fill the buffer past capacity with no idling, then read
  task automatic test_overflow();
    write_reg(RegBins, 128);
    quiet = 1'b1;
    while (!drop_seen || held_samples.size() < MaxSamples)
      push_sample(cluster_base + int'($urandom_range(0, 100000)), effective_component());
    push_sample(cluster_base, effective_component());
    repeat (12) read_bin($urandom_range(0, 127));
    read_bin(0);
    read_bin(127);
  endtask

  // Result side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      hold_left = 400;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 16);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result center=%h total=%0d status=%0d", $time,
                 out_bin_center, out_bin_total, out_read_status);
        error_count++;
      end else begin
        e = pending_bins.pop_front();
        checked_bins++;
        if (out_bin_center !== e.center) begin
          $display("%0t: bin_center expected %h actual %h", $time, e.center,
                   out_bin_center);
          error_count++;
        end
        if (out_bin_total !== e.total) begin
          $display("%0t: bin_total expected %0d actual %0d", $time, e.total,
                   out_bin_total);
          error_count++;
        end
        if (out_read_status !== e.status) begin
          $display("%0t: read_status expected %0d actual %0d", $time, e.status,
                   out_read_status);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_cmd = 1'b0;
    in_sample_value = '0;
    in_sample_component = '0;
    in_bin_index = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    stall_request = 1'b0;
    hold_left = 0;
    error_count = 0;
    counted_items = 0;
    read_transfers = 0;
    checked_bins = 0;
    drop_seen = 1'b0;
    tally_valid = 1'b0;
    low_val = 0;
    high_val = 0;
    reg_bins = 100;
    reg_sel = 0;
    reg_tot = 1;
    foreach (bin_tally[i]) bin_tally[i] = 0;
    cluster_base = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_flat();
    test_extremes();
    test_bin_count_limits();
    test_component_select();
    test_backpressure();
    test_random();
    test_overflow();

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Covered %0d counted transfers, %0d bin reads, %0d results checked,",
             counted_items, read_transfers, checked_bins);
    $display("including flat, full-scale, fallback-select and overflowed buffers.");
    if (error_count == 0 && pending_bins.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/arh_pkg.sv
hdl/arh_front.sv
hdl/arh_div.sv
hdl/arh_back.sv
hdl/auto_range_histogram.sv
tb/tb_auto_range_histogram.sv
